/* hw/rtl/dht_pkg.sv */
// Shared types and constants of the double-hash table unit.
package dht_pkg;

  localparam int HASH_W  = 10;
  localparam int HCNT_W  = $clog2(HASH_W);
  localparam int SLOT_W  = 10;
  localparam int TOTAL_W = 11;
  localparam int CFG_W   = 11;
  localparam int WORD_W  = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_DUP      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_VACATED = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD1,
    S_MOD2,
    S_READ,
    S_CHECK,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
    logic [HASH_W-1:0] hash_first;
    logic [HASH_W-1:0] hash_second;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [WORD_W-1:0]  found_value;
    logic [SLOT_W-1:0]  slot_index;
    logic [TOTAL_W-1:0] entry_total;
  } out_item_t;

  typedef struct packed {
    logic  data_en;
    logic  mark_en;
    mark_t mark;
  } wr_ctl_t;

endpackage

/* hw/rtl/dht_addmod.sv */
// Shared modular adder: (a + b + cin) mod n for a, b below n.
module dht_addmod #(
  parameter int W = 11
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         cin,
  input  logic [W-1:0] n,
  output logic [W-1:0] sum_mod
);

  logic [W:0] sum;

  assign sum     = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, cin};
  assign sum_mod = (sum >= {1'b0, n}) ? W'(sum - {1'b0, n}) : W'(sum);

endmodule

/* hw/rtl/dht_store.sv */
// Slot storage: key, value and mark memories with one read and one write port.
module dht_store #(
  parameter int SLOTS = 1024,
  parameter int KW    = 32
) (
  input  logic                      clk,
  input  logic [$clog2(SLOTS)-1:0]  rd_addr,
  output logic [KW-1:0]             rd_key,
  output logic [dht_pkg::WORD_W-1:0] rd_value,
  output dht_pkg::mark_t            rd_mark,
  input  logic [$clog2(SLOTS)-1:0]  wr_addr,
  input  dht_pkg::wr_ctl_t          wr_ctl,
  input  logic [KW-1:0]             wr_key,
  input  logic [dht_pkg::WORD_W-1:0] wr_value
);
  import dht_pkg::*;

  logic [KW-1:0]     keys   [SLOTS];
  logic [WORD_W-1:0] values [SLOTS];
  mark_t             marks  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_ctl.data_en) begin
      keys[wr_addr]   <= wr_key;
      values[wr_addr] <= wr_value;
    end
    if (wr_ctl.mark_en) begin
      marks[wr_addr] <= wr_ctl.mark;
    end
  end

  always_ff @(posedge clk) begin
    rd_key   <= keys[rd_addr];
    rd_value <= values[rd_addr];
    rd_mark  <= marks[rd_addr];
  end

endmodule

/* hw/rtl/double_hash_table_unit.sv */
// Top level of the double-hash table unit: sequencer, slot count and result register.
//
// Items arrive on in_valid/in_ready as in_item_t (lookup, insert or remove with key,
// value and two hashes); one result per item leaves on out_valid/out_ready as
// out_item_t. cfg_we/cfg_data set the slot count used as the probing modulus; the user
// must write it only while the unit is idle, as the block itself does not enforce this.
// Each item runs through one shared modular adder: two restoring reductions of the
// hashes in S_MOD1 and S_MOD2, then per probe a registered memory read in S_READ
// and a compare and step in S_CHECK. Unused opcodes and inserts into a full table
// skip the reductions and probes and go from S_IDLE straight to S_FINISH.
// One item is in work at a time; in_ready is high only between items.
// After reset the slot marks are swept to empty, one slot a cycle, with in_ready
// low; configuration writes are taken during the sweep.
// The result register holds while out_ready is low; the next item is accepted while
// a result waits, and that item's result holds inside the unit until the register
// frees.
module double_hash_table_unit #(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dht_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dht_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dht_pkg::out_item_t        out_data
);
  import dht_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int NW    = $clog2(SLOTS + 1);
  localparam int KW    = (KEY_BITS < WORD_W) ? KEY_BITS : WORD_W;

  seq_state_t        state, state_next;
  logic [NW-1:0]     n;
  logic [NW-1:0]     count, count_next;
  logic [IDX_W-1:0]  clr_addr, clr_addr_next;
  logic [NW-1:0]     r, r_next;
  logic [HCNT_W-1:0] cnt, cnt_next;
  logic [NW-1:0]     h1, h1_next;
  logic [NW-1:0]     h2, h2_next;
  logic [NW-1:0]     p, p_next;
  logic [NW-1:0]     i, i_next;
  logic              have_free, have_free_next;
  logic [NW-1:0]     free_slot, free_slot_next;
  logic [1:0]        op_q;
  logic [KW-1:0]     key_q;
  logic [WORD_W-1:0] value_q;
  logic [HASH_W-1:0] hash1_q, hash2_q;
  status_t           res_status, res_status_next;
  logic [WORD_W-1:0] res_fval, res_fval_next;
  logic [NW-1:0]     res_slot, res_slot_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  logic [NW-1:0]     am_a, am_b, am_out;
  logic              am_cin;
  logic [NW-1:0]     cfg_n;

  logic [KW-1:0]     rd_key;
  logic [WORD_W-1:0] rd_value;
  mark_t             rd_mark;
  logic [IDX_W-1:0]  wr_addr;
  wr_ctl_t           wr_ctl;

  logic              accept, hit, last, free_here, out_free;
  logic [NW-1:0]     free_pick;

  dht_addmod #(.W(NW)) u_addmod (
    .a       (am_a),
    .b       (am_b),
    .cin     (am_cin),
    .n       (n),
    .sum_mod (am_out)
  );

  dht_store #(.SLOTS(SLOTS), .KW(KW)) u_store (
    .clk      (clk),
    .rd_addr  (p[IDX_W-1:0]),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .rd_mark  (rd_mark),
    .wr_addr  (wr_addr),
    .wr_ctl   (wr_ctl),
    .wr_key   (key_q),
    .wr_value (value_q)
  );

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign hit       = (rd_mark == MARK_USED) && (rd_key == key_q);
  assign last      = (i == n - NW'(1));
  assign free_here = (rd_mark != MARK_USED);
  assign free_pick = have_free ? free_slot : p;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_n = NW'(1);
    end else if (32'(cfg_data) > SLOTS) begin
      cfg_n = NW'(SLOTS);
    end else begin
      cfg_n = NW'(cfg_data);
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    clr_addr_next   = clr_addr;
    r_next          = r;
    cnt_next        = cnt;
    h1_next         = h1;
    h2_next         = h2;
    p_next          = p;
    i_next          = i;
    have_free_next  = have_free;
    free_slot_next  = free_slot;
    res_status_next = res_status;
    res_fval_next   = res_fval;
    res_slot_next   = res_slot;
    out_valid_next  = out_valid && !out_ready;
    out_data_next   = out_data;
    wr_addr         = p[IDX_W-1:0];
    wr_ctl          = '{data_en: 1'b0, mark_en: 1'b0, mark: MARK_EMPTY};
    am_a            = p;
    am_b            = h2;
    am_cin          = 1'b0;

    case (state)
      S_CLEAR: begin
        wr_addr       = clr_addr;
        wr_ctl        = '{data_en: 1'b0, mark_en: 1'b1, mark: MARK_EMPTY};
        clr_addr_next = clr_addr + IDX_W'(1);
        if (clr_addr == IDX_W'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          r_next          = '0;
          cnt_next        = HCNT_W'(HASH_W - 1);
          i_next          = '0;
          have_free_next  = 1'b0;
          res_status_next = ST_NOTFOUND;
          res_fval_next   = '0;
          res_slot_next   = '0;
          case (in_data.opcode)
            OP_LOOKUP, OP_REMOVE: begin
              state_next = S_MOD1;
            end
            OP_INSERT: begin
              if (count >= n) begin
                res_status_next = ST_FULL;
                state_next      = S_FINISH;
              end else begin
                state_next = S_MOD1;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_MOD1: begin
        am_a   = r;
        am_b   = r;
        am_cin = hash1_q[cnt];
        if (cnt == '0) begin
          h1_next    = am_out;
          r_next     = '0;
          cnt_next   = HCNT_W'(HASH_W - 1);
          state_next = S_MOD2;
        end else begin
          r_next   = am_out;
          cnt_next = cnt - HCNT_W'(1);
        end
      end
      S_MOD2: begin
        am_a   = r;
        am_b   = r;
        am_cin = hash2_q[cnt];
        if (cnt == '0) begin
          h2_next    = (am_out == '0) ? NW'(1) : am_out;
          p_next     = h1;
          state_next = S_READ;
        end else begin
          r_next   = am_out;
          cnt_next = cnt - HCNT_W'(1);
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (hit) begin
          res_fval_next = rd_value;
          res_slot_next = p;
          state_next    = S_FINISH;
          if (op_q == OP_INSERT) begin
            res_status_next = ST_DUP;
          end else begin
            res_status_next = ST_OK;
            if (op_q == OP_REMOVE) begin
              wr_ctl = '{data_en: 1'b0, mark_en: 1'b1, mark: MARK_VACATED};
              if (count != '0) begin
                count_next = count - NW'(1);
              end
            end
          end
        end else if ((rd_mark == MARK_EMPTY) || last) begin
          state_next = S_FINISH;
          if ((op_q == OP_INSERT) && (have_free || free_here)) begin
            wr_addr         = free_pick[IDX_W-1:0];
            wr_ctl          = '{data_en: 1'b1, mark_en: 1'b1, mark: MARK_USED};
            count_next      = count + NW'(1);
            res_status_next = ST_OK;
            res_slot_next   = free_pick;
          end else if (op_q == OP_INSERT) begin
            res_status_next = ST_FULL;
          end
        end else begin
          if ((rd_mark == MARK_VACATED) && !have_free) begin
            have_free_next = 1'b1;
            free_slot_next = p;
          end
          p_next     = am_out;
          i_next     = i + NW'(1);
          state_next = S_READ;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_next            = 1'b1;
          out_data_next.status      = res_status;
          out_data_next.found_value = res_fval;
          out_data_next.slot_index  = SLOT_W'(res_slot);
          out_data_next.entry_total = TOTAL_W'(count);
          state_next                = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      count     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      n         <= NW'(SLOTS);
    end else begin
      state     <= state_next;
      count     <= count_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        n <= cfg_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    r          <= r_next;
    cnt        <= cnt_next;
    h1         <= h1_next;
    h2         <= h2_next;
    p          <= p_next;
    i          <= i_next;
    have_free  <= have_free_next;
    free_slot  <= free_slot_next;
    res_status <= res_status_next;
    res_fval   <= res_fval_next;
    res_slot   <= res_slot_next;
    out_data   <= out_data_next;
    if (accept) begin
      op_q    <= in_data.opcode;
      key_q   <= in_data.key[KW-1:0];
      value_q <= in_data.value;
      hash1_q <= in_data.hash_first;
      hash2_q <= in_data.hash_second;
    end
  end

endmodule

/* hw/rtl/dht_checker.sv */
// Port-level checks of the double-hash table unit, bound to the top level.
module dht_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input dht_pkg::out_item_t   out_data
);
  import dht_pkg::*;

  logic [TOTAL_W-1:0] last_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
    end else if (out_valid && out_ready) begin
      last_total <= out_data.entry_total;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("unit ready right after taking an item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_total_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && (out_data.status != ST_OK))
      |-> (out_data.entry_total == last_total))
    else $error("entry total moved on a failed item");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_data.status == ST_NOTFOUND) || (out_data.status == ST_FULL)))
      |-> ((out_data.found_value == '0) && (out_data.slot_index == '0)))
    else $error("miss result carries value or slot");

endmodule

bind double_hash_table_unit dht_checker u_dht_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* bench/double_hash_table_unit_checker.sv */
// Checker for the double-hash table unit: tracks the table, predicts each result and compares.
module double_hash_table_unit_checker #(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dht_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  dht_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  dht_pkg::out_item_t        out_data,
  output int                        errors,
  output int                        outstanding
);
  import dht_pkg::*;

  localparam logic [WORD_W-1:0] KEY_MASK =
    (KEY_BITS >= WORD_W) ? {WORD_W{1'b1}} : ((32'd1 << KEY_BITS) - 32'd1);

  logic [WORD_W-1:0] slot_key   [SLOTS];
  logic [WORD_W-1:0] slot_val   [SLOTS];
  mark_t             slot_mark  [SLOTS];
  int unsigned       live_count;
  logic [CFG_W-1:0]  slot_cfg;
  out_item_t         pending_results[$];
  out_item_t         want;
  out_item_t         fresh;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned active_slots();
    int unsigned n;
    n = slot_cfg;
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic int find_slot(input logic [WORD_W-1:0] k, input int unsigned h1,
                                   input int unsigned h2, input int unsigned n);
    int unsigned p;
    for (int unsigned i = 0; i < n; i++) begin
      p = (h1 + i * h2) % n;
      if (slot_mark[p] == MARK_EMPTY) return -1;
      if (slot_mark[p] == MARK_USED && slot_key[p] == k) return int'(p);
    end
    return -1;
  endfunction

  task automatic run_table_op(input in_item_t it, output out_item_t res);
    int unsigned n;
    int unsigned h1;
    int unsigned h2;
    int unsigned p;
    int unsigned slot;
    int hit;
    bit placed;
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] fv;
    status_t st;
    n  = active_slots();
    k  = it.key & KEY_MASK;
    h1 = it.hash_first % n;
    h2 = it.hash_second % n;
    if (h2 == 0) h2 = 1;
    st = ST_NOTFOUND;
    fv = '0;
    slot = 0;
    placed = 1'b0;
    case (it.opcode)
      OP_LOOKUP, OP_REMOVE: begin
        hit = find_slot(k, h1, h2, n);
        if (hit >= 0) begin
          st   = ST_OK;
          slot = hit;
          fv   = slot_val[hit];
          if (it.opcode == OP_REMOVE) begin
            slot_mark[hit] = MARK_VACATED;
            if (live_count > 0) live_count--;
          end
        end
      end
      OP_INSERT: begin
        if (live_count >= n) begin
          st = ST_FULL;
        end else begin
          hit = find_slot(k, h1, h2, n);
          if (hit >= 0) begin
            st   = ST_DUP;
            slot = hit;
            fv   = slot_val[hit];
          end else begin
            st = ST_FULL;
            for (int unsigned i = 0; i < n && !placed; i++) begin
              p = (h1 + i * h2) % n;
              if (slot_mark[p] != MARK_USED) begin
                slot_mark[p] = MARK_USED;
                slot_key[p]  = k;
                slot_val[p]  = it.value;
                live_count++;
                st     = ST_OK;
                slot   = p;
                placed = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.status      = st;
    res.found_value = fv;
    res.slot_index  = SLOT_W'(slot);
    res.entry_total = TOTAL_W'(live_count);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_mark[i] = MARK_EMPTY;
      live_count = 0;
      slot_cfg   = CFG_W'(SLOTS);
      errors     = 0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) slot_cfg = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result item with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status)
            note_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
          if (out_data.found_value !== want.found_value)
            note_mismatch($sformatf("found_value got %h want %h",
                                    out_data.found_value, want.found_value));
          if (out_data.slot_index !== want.slot_index)
            note_mismatch($sformatf("slot_index got %0d want %0d",
                                    out_data.slot_index, want.slot_index));
          if (out_data.entry_total !== want.entry_total)
            note_mismatch($sformatf("entry_total got %0d want %0d",
                                    out_data.entry_total, want.entry_total));
        end
      end
      if (in_valid && in_ready) begin
        run_table_op(in_data, fresh);
        pending_results.push_back(fresh);
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

/* bench/double_hash_table_unit_tb.sv */
// Testbench top for the double-hash table unit: clock, reset, stimulus and verdict.
module double_hash_table_unit_tb;
  import dht_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_MAX = 24;
  localparam int PHASES   = 11;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  int                 errors;
  int                 outstanding;

  bit                 steady;
  bit                 hold_req;
  bit                 hold_done;

  logic [WORD_W-1:0]  pool_key [POOL_MAX];
  logic [HASH_W-1:0]  pool_h1  [POOL_MAX];
  logic [HASH_W-1:0]  pool_h2  [POOL_MAX];
  int                 pool_size;

  int phase_cfg [PHASES] = '{1, 2, 3, 7, 16, 64, 0, 5, 1024, 2047, 31};
  int phase_len [PHASES] = '{40, 40, 50, 60, 80, 80, 30, 60, 60, 40, 60};

  double_hash_table_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  double_hash_table_unit_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(input logic [1:0] op, input logic [WORD_W-1:0] k,
                                         input logic [WORD_W-1:0] v,
                                         input logic [HASH_W-1:0] a,
                                         input logic [HASH_W-1:0] b);
    in_item_t it;
    it.opcode      = op;
    it.key         = k;
    it.value       = v;
    it.hash_first  = a;
    it.hash_second = b;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_slots(input int v);
    cfg_data <= CFG_W'(v);
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic refill_pool(input int slots);
    int r;
    pool_size = (slots + 3 < POOL_MAX) ? slots + 3 : POOL_MAX;
    for (int j = 0; j < pool_size; j++) begin
      r = $urandom_range(0, 99);
      if (r < 5) pool_key[j] = '0;
      else if (r < 10) pool_key[j] = '1;
      else pool_key[j] = $urandom;
      pool_h1[j] = $urandom_range(0, 1023);
      pool_h2[j] = $urandom_range(0, 1023);
    end
  endtask

  task automatic random_item(output in_item_t it);
    int r;
    int j;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    j = $urandom_range(0, pool_size - 1);
    if (r < 90) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_INSERT;
      else if (r < 70) op = OP_LOOKUP;
      else op = OP_REMOVE;
      it = make_item(op, pool_key[j], $urandom, pool_h1[j], pool_h2[j]);
    end else if (r < 95) begin
      it = make_item(2'($urandom_range(0, 3)), pool_key[j], $urandom,
                     10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end else begin
      it = make_item(2'($urandom_range(0, 3)), $urandom, $urandom,
                     10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (500) @(negedge clk);
        hold_done = 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  initial begin
    in_item_t it;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    pool_size = 1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_slots(4);

    send_item(make_item(OP_LOOKUP, 32'h0, 32'h0, 10'd0, 10'd0));
    send_item(make_item(OP_INSERT, 32'h0, 32'h0, 10'd0, 10'd0));
    send_item(make_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023));
    send_item(make_item(OP_INSERT, 32'h0, 32'h5, 10'd0, 10'd0));
    send_item(make_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 10'd1023, 10'd1023));
    send_item(make_item(OP_REMOVE, 32'h0, 32'h0, 10'd0, 10'd0));
    send_item(make_item(OP_LOOKUP, 32'h0, 32'h0, 10'd0, 10'd0));
    send_item(make_item(OP_INSERT, 32'h1234_5678, 32'hA5A5_5A5A, 10'd0, 10'd1));
    send_item(make_item(OP_UNUSED, 32'h1234_5678, 32'h0, 10'd0, 10'd1));
    send_item(make_item(OP_INSERT, 32'h1, 32'h11, 10'd1, 10'd2));
    send_item(make_item(OP_INSERT, 32'h2, 32'h22, 10'd1, 10'd2));
    send_item(make_item(OP_INSERT, 32'h3, 32'h33, 10'd2, 10'd1));
    send_item(make_item(OP_INSERT, 32'h4, 32'h44, 10'd0, 10'd1));
    send_item(make_item(OP_REMOVE, 32'h5, 32'h0, 10'd0, 10'd1));
    send_item(make_item(OP_REMOVE, 32'h1, 32'h0, 10'd1, 10'd2));
    send_item(make_item(OP_LOOKUP, 32'h2, 32'h0, 10'd1, 10'd2));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_slots(phase_cfg[ph]);
      refill_pool((phase_cfg[ph] < 1) ? 1 : phase_cfg[ph]);
      steady = (ph == 3 || ph == 7);
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < phase_len[ph]; k++) begin
        random_item(it);
        send_item(it);
      end
      drain();
    end

    steady = 1'b0;
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
